### hdl/cidat_pkg.sv
package cidat_pkg;

   localparam int ID_FIELD_BITS = 12;
   localparam int PAYLOAD_BITS  = 64;
   localparam int NIBBLE_BITS   = 5;
   localparam int REF_LEN_BITS  = 4;
   localparam int COUNT_FIELD_BITS = 32;
   localparam int CFG_BITS      = 32;

   localparam logic [NIBBLE_BITS-1:0] NIBBLES_MIN = 5'd1;
   localparam logic [NIBBLE_BITS-1:0] NIBBLES_MAX = 5'd16;
   localparam logic [CFG_BITS-1:0]    MIN_FRAMES_RESET = 32'd20;

   typedef enum logic {
      OP_RECORD = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   // mask covering the low 4*len bits, len already clamped to 1..16
   function automatic logic [PAYLOAD_BITS-1:0] nibble_mask(input logic [NIBBLE_BITS-1:0] len);
      logic [6:0]              sh;
      logic [PAYLOAD_BITS-1:0] m;
      sh = {len, 2'b00};
      if (len >= NIBBLES_MAX) begin
         m = '1;
      end else begin
         m = (64'd1 << sh) - 64'd1;
      end
      return m;
   endfunction

endpackage

### hdl/cidat_if.sv
interface cidat_req_if;
   import cidat_pkg::*;

   logic                          valid;
   logic                          ready;
   op_type                        operation;
   logic [ID_FIELD_BITS-1:0]      frame_id;
   logic [PAYLOAD_BITS-1:0]       payload;
   logic [NIBBLE_BITS-1:0]        payload_nibbles;

   modport source (output valid, operation, frame_id, payload, payload_nibbles, input ready);
   modport sink   (input valid, operation, frame_id, payload, payload_nibbles, output ready);
endinterface

interface cidat_rsp_if;
   import cidat_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          id_seen;
   logic [COUNT_FIELD_BITS-1:0]   frame_count;
   logic [COUNT_FIELD_BITS-1:0]   change_count;
   logic                          payload_changed;
   logic                          qualifies;

   modport source (output valid, id_seen, frame_count, change_count, payload_changed, qualifies,
                   input ready);
   modport sink   (input valid, id_seen, frame_count, change_count, payload_changed, qualifies,
                   output ready);
endinterface

### hdl/can_id_activity_table.sv
// can_id_activity_table: per-identifier frame statistics.
// req_ch carries one request: record a frame (identifier, payload, nibble
// length) or query an identifier. Every request gives exactly one response
// on rsp_ch: seen flag, frame count, change count, payload-changed flag and
// the qualifies flag against the threshold written on the csr_ port.
// csr_ is always ready; write it only while no request is in flight.
// Pipeline: an accepted request passes the read stage, then the response register.
// Throughput: one request per cycle while rsp_ch does not stall; the table is a
// single memory with one read and one write port, read-modify-write over two
// stages, and a write to the entry being read in the same cycle is forwarded.
// Reset: the threshold returns to 20 and a clearing pass writes all 2**ID_BITS
// table entries (4096 by default), one per cycle; req_ch.ready stays low until
// it ends.
// rsp_ch stall: the response register holds; the request in the read stage
// waits behind it and req_ch.ready drops until the response is taken.
module can_id_activity_table #(
   parameter int ID_BITS    = 12,
   parameter int COUNT_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   cidat_req_if.sink                   req_ch,
   cidat_rsp_if.source                 rsp_ch,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [cidat_pkg::CFG_BITS-1:0] csr_data
);
   import cidat_pkg::*;

   localparam int DEPTH = 1 << ID_BITS;

   typedef struct packed {
      logic                     seen;
      logic [COUNT_BITS-1:0]    frame_count;
      logic [COUNT_BITS-1:0]    change_count;
      logic [PAYLOAD_BITS-1:0]  payload;
      logic [REF_LEN_BITS-1:0]  ref_len;
   } entry_type;

   entry_type table_mem [DEPTH];

   logic [CFG_BITS-1:0]      min_frames_ff;
   logic                     clearing_ff, clearing_in;
   logic [ID_BITS-1:0]       clr_addr_ff, clr_addr_in;

   logic                     s1_valid_ff, s1_valid_in;
   op_type                   s1_op_ff;
   logic [ID_BITS-1:0]       s1_slot_ff;
   logic [PAYLOAD_BITS-1:0]  s1_data_ff;
   logic [REF_LEN_BITS-1:0]  s1_len_ff;
   entry_type                rd_ff;
   logic                     fwd_hit_ff, fwd_hit_in;
   entry_type                fwd_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_seen_ff, rsp_chg_ff, rsp_qual_ff;
   logic [COUNT_BITS-1:0]    rsp_fc_ff, rsp_cc_ff;

   logic                     s1_adv, req_acc;
   logic [NIBBLE_BITS-1:0]   len_c;
   logic [ID_BITS-1:0]       req_slot;
   logic [PAYLOAD_BITS-1:0]  req_data;
   logic [REF_LEN_BITS-1:0]  req_len;
   entry_type                cur, new_entry, res_entry, wr_data;
   logic [COUNT_BITS-1:0]    fc_inc, cc_inc;
   logic                     changed, chg_out, qual;
   logic                     wr_en;
   logic [ID_BITS-1:0]       wr_addr;

   assign csr_ready = 1'b1;

   always_comb begin
      s1_adv  = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
      req_ch.ready = !clearing_ff && (!s1_valid_ff || s1_adv);
      req_acc = req_ch.valid && req_ch.ready;

      if (req_ch.payload_nibbles < NIBBLES_MIN) begin
         len_c = NIBBLES_MIN;
      end else if (req_ch.payload_nibbles > NIBBLES_MAX) begin
         len_c = NIBBLES_MAX;
      end else begin
         len_c = req_ch.payload_nibbles;
      end
      req_len  = REF_LEN_BITS'(len_c - NIBBLES_MIN);
      req_data = req_ch.payload & nibble_mask(len_c);
      req_slot = ID_BITS'(req_ch.frame_id);

      cur    = fwd_hit_ff ? fwd_ff : rd_ff;
      fc_inc = (cur.frame_count == '1) ? cur.frame_count : cur.frame_count + COUNT_BITS'(1);
      cc_inc = (cur.change_count == '1) ? cur.change_count : cur.change_count + COUNT_BITS'(1);
      changed = (cur.payload != s1_data_ff) || (cur.ref_len != s1_len_ff);

      if (!cur.seen) begin
         new_entry.seen         = 1'b1;
         new_entry.frame_count  = COUNT_BITS'(1);
         new_entry.change_count = '0;
         new_entry.payload      = s1_data_ff;
         new_entry.ref_len      = s1_len_ff;
      end else begin
         new_entry              = cur;
         new_entry.frame_count  = fc_inc;
         new_entry.change_count = changed ? cc_inc : cur.change_count;
      end

      if (s1_op_ff == OP_RECORD) begin
         res_entry = new_entry;
         chg_out   = cur.seen && changed;
      end else begin
         res_entry = cur;
         chg_out   = 1'b0;
      end
      qual = res_entry.seen && (CFG_BITS'(res_entry.frame_count) >= min_frames_ff)
             && (res_entry.change_count != '0);

      wr_en   = clearing_ff || (s1_adv && s1_op_ff == OP_RECORD);
      wr_addr = clearing_ff ? clr_addr_ff : s1_slot_ff;
      wr_data = clearing_ff ? entry_type'('0) : new_entry;
      fwd_hit_in = wr_en && (wr_addr == req_slot);

      clearing_in = clearing_ff && (clr_addr_ff != '1);
      clr_addr_in = clr_addr_ff + ID_BITS'(1);

      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_frames_ff <= MIN_FRAMES_RESET;
         clearing_ff   <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            min_frames_ff <= csr_data;
         end
         clearing_ff  <= clearing_in;
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (req_acc) begin
         rd_ff <= table_mem[req_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_op_ff   <= req_ch.operation;
         s1_slot_ff <= req_slot;
         s1_data_ff <= req_data;
         s1_len_ff  <= req_len;
         fwd_hit_ff <= fwd_hit_in;
         fwd_ff     <= wr_data;
      end
      if (s1_adv) begin
         rsp_seen_ff <= res_entry.seen;
         rsp_fc_ff   <= res_entry.seen ? res_entry.frame_count : '0;
         rsp_cc_ff   <= res_entry.seen ? res_entry.change_count : '0;
         rsp_chg_ff  <= chg_out;
         rsp_qual_ff <= qual;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.id_seen         = rsp_seen_ff;
   assign rsp_ch.frame_count     = COUNT_FIELD_BITS'(rsp_fc_ff);
   assign rsp_ch.change_count    = COUNT_FIELD_BITS'(rsp_cc_ff);
   assign rsp_ch.payload_changed = rsp_chg_ff;
   assign rsp_ch.qualifies       = rsp_qual_ff;

endmodule

### hdl/cidat_checker.sv
module cidat_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        id_seen,
   input logic [31:0] frame_count,
   input logic [31:0] change_count,
   input logic        payload_changed,
   input logic        qualifies
);

   // clearing pass blocks requests right after reset
   a_ready_after_reset: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted during clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_unseen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !id_seen |-> frame_count == 32'd0 && change_count == 32'd0
                                && !payload_changed && !qualifies)
      else $error("unseen identifier reports statistics");

   a_changed_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && payload_changed |-> id_seen && change_count != 32'd0
                                       && frame_count > 32'd1)
      else $error("change flag without counted change");

   a_qual_needs_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && qualifies |-> change_count != 32'd0 && frame_count != 32'd0)
      else $error("qualifies without a change");

endmodule

bind can_id_activity_table cidat_checker u_cidat_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .id_seen         (rsp_ch.id_seen),
   .frame_count     (rsp_ch.frame_count),
   .change_count    (rsp_ch.change_count),
   .payload_changed (rsp_ch.payload_changed),
   .qualifies       (rsp_ch.qualifies)
);
